// ===== hw/rtl/egcd_pkg.sv =====
// Shared constants, state encoding and command/status types of the extended gcd block.
package egcd_pkg;

  localparam int WIDTH      = 32;
  localparam int OPND_W     = WIDTH - 1;
  localparam int COEFF_W    = WIDTH;
  localparam int STEP_LIMIT = 2 * WIDTH + 2;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
  localparam int ADDR_W     = $clog2(STEP_LIMIT);
  localparam int BIT_W      = $clog2(OPND_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WRITE,
    ST_BACK,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } egcd_state_t;

  typedef struct packed {
    logic load;        // latch operands, seed coefficients
    logic div_start;   // seed the divider
    logic div_step;    // one restoring-division bit
    logic div_finish;  // store quotient, shift remainders
    logic rd;          // read stored quotient
    logic mul;         // form q * y
    logic upd;         // apply x = y, y = x - q*y
    logic out_load;    // capture the result word
  } egcd_cmd_t;

  typedef struct packed {
    logic lo_zero;
    logic steps_full;
    logic steps_zero;
    logic bit_last;
  } egcd_sts_t;

endpackage

// ===== hw/rtl/egcd_channels.sv =====
// Handshake channel interfaces for the operand and result words.
interface egcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [egcd_pkg::OPND_W-1:0] a_value;
  logic [egcd_pkg::OPND_W-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink (input valid, input a_value, input b_value, output ready);
endinterface

interface egcd_out_if;
  logic                               valid;
  logic                               ready;
  logic        [egcd_pkg::OPND_W-1:0]  divisor;
  logic signed [egcd_pkg::COEFF_W-1:0] coeff_x;
  logic signed [egcd_pkg::COEFF_W-1:0] coeff_y;

  modport source (output valid, output divisor, output coeff_x, output coeff_y, input ready);
  modport sink (input valid, input divisor, input coeff_x, input coeff_y, output ready);
endinterface

// ===== hw/rtl/extended_gcd.sv =====
// Top level of the extended gcd block: controller, datapath and checks.
//
//   channel    dir   word fields                      handshake
//   operands   in    a_value, b_value (31b unsigned)  valid/ready
//   results    out   divisor (31b), coeff_x, coeff_y  valid/ready
//                    (32b two's complement)
//
// One word is worked on at a time. Each quotient step of the forward pass is
// one check, 31 restoring-division bits and one store; the unwind does a
// memory read, a multiply and an update per stored quotient. For 31-bit
// operands a word has at most 45 quotient steps.
// Reset clears the controller state and the result valid flag; the quotient
// store and the payload registers need no reset.
// A new operand word is taken while an earlier result still waits; a stalled
// result sink only holds the finished word back in the last state.
module extended_gcd (
  input logic       clk,
  input logic       rst,
  egcd_in_if.sink   operands,
  egcd_out_if.source results
);
  import egcd_pkg::*;

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  egcd_dpath u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .a_value (operands.a_value),
    .b_value (operands.b_value),
    .divisor (results.divisor),
    .coeff_x (results.coeff_x),
    .coeff_y (results.coeff_y)
  );

  // Take one operand word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("operand word taken while busy");

  // Never overwrite a result word that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!results.valid || results.ready))
    else $error("pending result overwritten");

  // A captured result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> results.valid)
    else $error("captured result not offered");

  // 31-bit operands never reach the quotient step limit.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.steps_full)
    else $error("quotient step limit reached");

endmodule

// ===== hw/rtl/egcd_dpath.sv =====
// Datapath: restoring divider, quotient store and coefficient unwind unit.
module egcd_dpath (
  input  logic                               clk,
  input  egcd_pkg::egcd_cmd_t                cmd,
  output egcd_pkg::egcd_sts_t                sts,
  input  logic        [egcd_pkg::OPND_W-1:0]  a_value,
  input  logic        [egcd_pkg::OPND_W-1:0]  b_value,
  output logic        [egcd_pkg::OPND_W-1:0]  divisor,
  output logic signed [egcd_pkg::COEFF_W-1:0] coeff_x,
  output logic signed [egcd_pkg::COEFF_W-1:0] coeff_y
);
  import egcd_pkg::*;

  logic [OPND_W-1:0]  rem_hi;
  logic [OPND_W-1:0]  rem_lo;
  logic [OPND_W-1:0]  part_rem;
  logic [OPND_W-1:0]  quo;
  logic [BIT_W-1:0]   bit_cnt;
  logic [STEP_W-1:0]  steps;
  logic [COEFF_W-1:0] cx;
  logic [COEFF_W-1:0] cy;
  logic [COEFF_W-1:0] prod;
  logic [OPND_W-1:0]  q_rd;
  logic [OPND_W-1:0]  qmem [STEP_LIMIT];

  logic [OPND_W:0]    shifted;
  logic [OPND_W+1:0]  trial;
  logic [STEP_W-1:0]  rd_index;
  logic [COEFF_W-1:0] q_ext;

  assign shifted  = {part_rem, quo[OPND_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, rem_lo};
  assign rd_index = steps - STEP_W'(1);
  assign q_ext    = {{(COEFF_W - OPND_W){1'b0}}, q_rd};

  // Divider and remainder pair.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_hi <= a_value;
      rem_lo <= b_value;
    end else if (cmd.div_finish) begin
      rem_hi <= rem_lo;
      rem_lo <= part_rem;
    end
    if (cmd.div_start) begin
      part_rem <= '0;
      quo      <= rem_hi;
      bit_cnt  <= '0;
    end else if (cmd.div_step) begin
      if (trial[OPND_W+1]) begin
        part_rem <= shifted[OPND_W-1:0];
      end else begin
        part_rem <= trial[OPND_W-1:0];
      end
      quo     <= {quo[OPND_W-2:0], ~trial[OPND_W+1]};
      bit_cnt <= bit_cnt + BIT_W'(1);
    end
  end

  // Step count: counts up on the forward pass, down on the unwind.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps <= '0;
    end else if (cmd.div_finish) begin
      steps <= steps + STEP_W'(1);
    end else if (cmd.upd) begin
      steps <= rd_index;
    end
  end

  // Quotient store.
  always_ff @(posedge clk) begin
    if (cmd.div_finish) begin
      qmem[steps[ADDR_W-1:0]] <= quo;
    end
    if (cmd.rd) begin
      q_rd <= qmem[rd_index[ADDR_W-1:0]];
    end
  end

  // Coefficient unwind, wrapping at the coefficient width.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= COEFF_W'(1);
      cy <= '0;
    end else if (cmd.upd) begin
      cx <= cy;
      cy <= cx - prod;
    end
    if (cmd.mul) begin
      prod <= q_ext * cy;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      divisor <= rem_hi;
      coeff_x <= cx;
      coeff_y <= cy;
    end
  end

  assign sts.lo_zero    = (rem_lo == '0);
  assign sts.steps_full = (steps == STEP_W'(STEP_LIMIT));
  assign sts.steps_zero = (steps == '0);
  assign sts.bit_last   = (bit_cnt == BIT_W'(OPND_W - 1));

endmodule

// ===== hw/rtl/egcd_ctrl.sv =====
// Controller: sequences division steps, the unwind pass and the result hand-off.
module egcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  egcd_pkg::egcd_sts_t sts,
  output egcd_pkg::egcd_cmd_t cmd
);
  import egcd_pkg::*;

  egcd_state_t state;
  egcd_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.lo_zero || sts.steps_full) begin
          state_next = ST_BACK;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.bit_last) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_CHECK;
      ST_BACK: begin
        if (sts.steps_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_BACK;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Refuse operands while reset is held.
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_CHECK: cmd.div_start = !(sts.lo_zero || sts.steps_full);
      ST_DIV:   cmd.div_step = 1'b1;
      ST_WRITE: cmd.div_finish = 1'b1;
      ST_BACK:  cmd.rd = !sts.steps_zero;
      ST_MUL:   cmd.mul = 1'b1;
      ST_UPD:   cmd.upd = 1'b1;
      ST_DONE:  cmd.out_load = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== tb/tb_extended_gcd.sv =====
// Self-checking testbench for the extended gcd block: directed table, then random operand words.
module tb_extended_gcd;
  import egcd_pkg::*;

  // Largest operand value the 31-bit fields can carry.
  localparam logic [OPND_W-1:0] OP_MAX = {OPND_W{1'b1}};

  localparam int NUM_DIR      = 23;
  localparam int NUM_RANDOM   = 350;
  // A word has up to 45 quotient steps: wait out at least one full word
  // after the last expected result has arrived.
  localparam int DRAIN_CYCLES = 2000;
  // Slowest correct run: ~375 words of up to 45 quotient steps each, plus the
  // longest sender gap and receiver stall per word and the one long hold-off.
  // Take that several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  // Long receiver hold-off: long enough for the block to finish the word in
  // hand, take one more and then refuse further operands.
  localparam int HOLD_AFTER   = 30;
  localparam int HOLD_CYCLES  = 8000;

  // gcd with its Bezout coefficients, as carried by one result word.
  typedef struct packed {
    logic [OPND_W-1:0]  divisor;
    logic [COEFF_W-1:0] coeff_x;
    logic [COEFF_W-1:0] coeff_y;
  } gcd_triple_t;

  // Expected result kept together with the operands that caused it.
  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    gcd_triple_t       triple;
  } pending_word_t;

  // One row of the directed table; the typed answer is used only when known.
  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic              known;
    gcd_triple_t       triple;
  } stim_row_t;

  logic clk;
  logic rst;

  egcd_in_if  operands_ch();
  egcd_out_if results_ch();

  extended_gcd uut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .results  (results_ch)
  );

  pending_word_t awaited_words[$];
  pending_word_t oldest_word;
  int            errors        = 0;
  int            results_taken = 0;
  int            cycle_count   = 0;
  int            tx_idle_pct   = 20;
  int            rx_stall_pct  = 20;
  bit            rx_holding    = 1'b0;
  bit            held_off      = 1'b0;

  // Directed words: zero operands, extremes, equal operands, swapped order,
  // a worst-case Fibonacci pair and alternating bit patterns.
  stim_row_t dir_rows [NUM_DIR] = '{
    '{31'd0,              31'd0,              1'b1, '{31'd0,     32'sd1, 32'sd0}},
    '{31'd0,              OP_MAX,             1'b1, '{OP_MAX,    32'sd0, 32'sd1}},
    '{OP_MAX,             31'd0,              1'b1, '{OP_MAX,    32'sd1, 32'sd0}},
    '{OP_MAX,             OP_MAX,             1'b1, '{OP_MAX,    32'sd0, 32'sd1}},
    '{31'd1,              31'd1,              1'b1, '{31'd1,     32'sd0, 32'sd1}},
    '{31'd0,              31'd1,              1'b1, '{31'd1,     32'sd0, 32'sd1}},
    '{31'd1,              31'd0,              1'b1, '{31'd1,     32'sd1, 32'sd0}},
    '{31'd12345,          31'd12345,          1'b1, '{31'd12345, 32'sd0, 32'sd1}},
    '{31'd0,              31'd77,             1'b1, '{31'd77,    32'sd0, 32'sd1}},
    '{OP_MAX,             OP_MAX - 31'd1,     1'b1, '{31'd1,     32'sd1, -32'sd1}},
    '{OP_MAX - 31'd1,     OP_MAX,             1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd240,            31'd46,             1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd46,             31'd240,            1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd1836311903,     31'd1134903170,     1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd1134903170,     31'd1836311903,     1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{OP_MAX,             31'd1,              1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd1,              OP_MAX,             1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'h5555_5555,      31'h2AAA_AAAA,      1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'h2AAA_AAAA,      31'h5555_5555,      1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'h4000_0000,      31'h2000_0001,      1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd223092870,      OP_MAX - 31'd1,     1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{31'd1000000007,     31'd998244353,      1'b0, '{31'd0,     32'sd0, 32'sd0}},
    '{OP_MAX,             31'd2,              1'b0, '{31'd0,     32'sd0, 32'sd0}}
  };

  // Free-running clock, period 20.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Forward pass records every quotient until the remainder vanishes or the step
  // limit is hit, then unwind them: x = y1, y = x1 - q*y1, all arithmetic wrapping at 64 bits.
  function automatic gcd_triple_t egcd_predict(input logic [OPND_W-1:0] a,
                                               input logic [OPND_W-1:0] b);
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned rem;
    longint unsigned cx;
    longint unsigned cy;
    longint unsigned nx;
    longint unsigned quot [STEP_LIMIT];
    int              n;
    int              i;
    gcd_triple_t     res;
    hi = 64'(a);
    lo = 64'(b);
    cx = 64'd1;
    cy = 64'd0;
    n  = 0;
    while (lo != 0 && n < STEP_LIMIT) begin
      quot[n] = hi / lo;
      rem     = hi % lo;
      n++;
      hi = lo;
      lo = rem;
    end
    for (i = n - 1; i >= 0; i--) begin
      nx = cy;
      cy = cx - quot[i] * cy;
      cx = nx;
    end
    res.divisor = hi[OPND_W-1:0];
    res.coeff_x = cx[COEFF_W-1:0];
    res.coeff_y = cy[COEFF_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, some medium, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 24);
    else
      return $urandom_range(60, 400);
  endfunction

  // Idling density for the next stretch: none, light or heavy.
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Random operand pair; most pairs have some structure so that the quotient
  // chain is long, short, or ends on a large common factor.
  function automatic void draw_operands(output logic [OPND_W-1:0] a,
                                        output logic [OPND_W-1:0] b);
    int              kind;
    int              w;
    logic [31:0]     mask;
    longint unsigned f0;
    longint unsigned f1;
    longint unsigned f2;
    longint unsigned g;
    longint unsigned m;
    longint unsigned n;
    logic [OPND_W-1:0] t;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // full-width random bits
      a = OPND_W'($urandom);
      b = OPND_W'($urandom);
    end else if (kind < 50) begin
      // random bit widths, unrelated for each operand
      w    = $urandom_range(1, OPND_W);
      mask = (32'h1 << w) - 32'h1;
      a    = OPND_W'($urandom & mask);
      w    = $urandom_range(1, OPND_W);
      mask = (32'h1 << w) - 32'h1;
      b    = OPND_W'($urandom & mask);
    end else if (kind < 60) begin
      a = OPND_W'($urandom_range(0, 50));
      b = OPND_W'($urandom_range(0, 50));
    end else if (kind < 75) begin
      // shared factor
      g = 64'($urandom_range(1, 65535));
      m = 64'($urandom_range(0, 32'(64'(OP_MAX) / g)));
      n = 64'($urandom_range(0, 32'(64'(OP_MAX) / g)));
      a = OPND_W'(g * m);
      b = OPND_W'(g * n);
    end else if (kind < 85) begin
      // consecutive terms of a Fibonacci-like run: the longest chains
      f0 = 64'($urandom_range(0, 5));
      f1 = 64'($urandom_range(1, 8));
      while (f0 + f1 <= 64'(OP_MAX)) begin
        f2 = f0 + f1;
        f0 = f1;
        f1 = f2;
      end
      a = OPND_W'(f1);
      b = OPND_W'(f0);
    end else if (kind < 95) begin
      // one operand divides the other
      g = 64'($urandom_range(1, 65535));
      m = 64'($urandom_range(0, 32'(64'(OP_MAX) / g)));
      a = OPND_W'(g * m);
      b = OPND_W'(g);
    end else begin
      // zero or equal operands
      a = OPND_W'($urandom);
      b = $urandom_range(0, 1) ? a : 31'd0;
    end
    if ($urandom_range(0, 1)) begin
      t = a;
      a = b;
      b = t;
    end
  endfunction

  // Offer one operand word and hold it until taken; record the expected
  // result at the accepting edge. Drop valid for a gap only when idling is
  // due, and never while the receiver holds off, so the block fills up.
  task automatic offer_word(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                            input gcd_triple_t triple, input bit last_word);
    pending_word_t entry;
    operands_ch.valid   <= 1'b1;
    operands_ch.a_value <= a;
    operands_ch.b_value <= b;
    do @(posedge clk); while (!operands_ch.ready);
    entry.a      = a;
    entry.b      = b;
    entry.triple = triple;
    awaited_words.push_back(entry);
    if ($urandom_range(0, 19) == 0)
      tx_idle_pct = pick_idle_pct();
    if (last_word) begin
      operands_ch.valid <= 1'b0;
    end else if (!rx_holding && $urandom_range(0, 99) < tx_idle_pct) begin
      operands_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Operand sender and end of run.
  initial begin
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    gcd_triple_t       triple;
    int                k;
    rst                 = 1'b1;
    operands_ch.valid   = 1'b0;
    operands_ch.a_value = '0;
    operands_ch.b_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table: use the typed answer where given, else the predictor.
    for (k = 0; k < NUM_DIR; k++) begin
      triple = dir_rows[k].known ? dir_rows[k].triple
                                 : egcd_predict(dir_rows[k].a, dir_rows[k].b);
      offer_word(dir_rows[k].a, dir_rows[k].b, triple, 1'b0);
    end

    for (k = 0; k < NUM_RANDOM; k++) begin
      draw_operands(a, b);
      offer_word(a, b, egcd_predict(a, b), k == NUM_RANDOM - 1);
    end

    // Wait for every outstanding word, then a full word time more so that a
    // stray extra result would still be caught.
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_extended_gcd: clean");
    else
      $display("tb_extended_gcd: errors");
    $finish;
  end

  // Result receiver: random stalls in stretches of varying density, and once
  // a long hold-off counted here while the sender keeps offering.
  initial begin
    int hold_count;
    results_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rx_stall_pct = pick_idle_pct();
      if (!held_off && results_taken >= HOLD_AFTER) begin
        held_off   = 1'b1;
        rx_holding = 1'b1;
        results_ch.ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
          @(posedge clk);
        rx_holding = 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        results_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        results_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result word, field by field, with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      results_taken++;
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word: divisor %0d x %0d y %0d", $time,
                 results_ch.divisor, results_ch.coeff_x, results_ch.coeff_y);
        errors++;
      end else begin
        oldest_word = awaited_words.pop_front();
        if (results_ch.divisor !== oldest_word.triple.divisor) begin
          $display("%0t: gcd(%0d, %0d) divisor: expected %0d, got %0d", $time,
                   oldest_word.a, oldest_word.b, oldest_word.triple.divisor,
                   results_ch.divisor);
          errors++;
        end
        if (results_ch.coeff_x !== oldest_word.triple.coeff_x) begin
          $display("%0t: gcd(%0d, %0d) coeff_x: expected %0d, got %0d", $time,
                   oldest_word.a, oldest_word.b, $signed(oldest_word.triple.coeff_x),
                   results_ch.coeff_x);
          errors++;
        end
        if (results_ch.coeff_y !== oldest_word.triple.coeff_y) begin
          $display("%0t: gcd(%0d, %0d) coeff_y: expected %0d, got %0d", $time,
                   oldest_word.a, oldest_word.b, $signed(oldest_word.triple.coeff_y),
                   results_ch.coeff_y);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d words outstanding", $time,
               awaited_words.size());
      $display("tb_extended_gcd: errors");
      $finish;
    end
  end

endmodule
